@@ hw/rtl/fqd_pkg.sv @@
`timescale 1ns / 1ps

package fqd_pkg;

   // cordic iteration count, capped at the arctangent table length
   localparam int CORDIC_STAGES  = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam int CORDIC_ITER    = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
                                   CORDIC_STAGES : ATAN_TABLE_LEN;

   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 2 * SAMPLE_W;
   localparam int MIX_W       = PROD_W + 1;
   localparam int XY_W        = MIX_W + 3;
   localparam int Z_W         = 34;
   localparam int ANGLE_SHIFT = 16;
   localparam int ANGLE_W     = 18;
   localparam int GAIN_W      = 16;
   localparam int SCALED_W    = ANGLE_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 11;
   localparam int ROUNDED_W   = SCALED_W - ROUND_SHIFT;
   localparam int FREQ_W      = 21;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8250;

   // +pi in accumulator units of pi/2^31
   localparam logic signed [Z_W-1:0] PI_Z = 34'sd2147483648;

   localparam logic signed [ROUNDED_W-1:0] FREQ_MAX = 24'sd1048575;
   localparam logic signed [ROUNDED_W-1:0] FREQ_MIN = -24'sd1048576;

   // atan(2^-k) in units of pi/2^31, rounded to nearest
   localparam logic [Z_W-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      34'd536870912, 34'd316933406, 34'd167458907, 34'd85004756,
      34'd42667331,  34'd21354465,  34'd10679838,  34'd5340245,
      34'd2670163,   34'd1335087,   34'd667544,    34'd333772,
      34'd166886,    34'd83443,     34'd41722,     34'd20861,
      34'd10430,     34'd5215,      34'd2608,      34'd1304,
      34'd652,       34'd326,       34'd163,       34'd81
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } cordic_vec_type;

endpackage

@@ hw/rtl/fqd_mixer.sv @@
`timescale 1ns / 1ps

module fqd_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [fqd_pkg::SAMPLE_W-1:0]   in_i,
   input  logic signed [fqd_pkg::SAMPLE_W-1:0]   in_q,
   input  logic                                  in_open,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [fqd_pkg::MIX_W-1:0]      out_re,
   output logic signed [fqd_pkg::MIX_W-1:0]      out_im
);

   logic signed [fqd_pkg::SAMPLE_W-1:0] last_i_ff, last_q_ff;
   logic signed [fqd_pkg::SAMPLE_W-1:0] cur_i_in, cur_q_in;
   logic signed [fqd_pkg::PROD_W-1:0]   p_ii_ff, p_qq_ff, p_qi_ff, p_iq_ff;
   logic signed [fqd_pkg::MIX_W-1:0]    re_ff, im_ff, re_in, im_in;
   logic                                vld1_ff, vld2_ff;
   logic                                load1, load2, accept;

   assign load2    = !vld2_ff || out_ready;
   assign load1    = !vld1_ff || load2;
   assign in_ready = load1;
   assign accept   = in_valid && load1;

   // closed squelch replaces the sample by zero
   assign cur_i_in = in_open ? in_i : '0;
   assign cur_q_in = in_open ? in_q : '0;

   assign re_in = fqd_pkg::MIX_W'(p_ii_ff) + fqd_pkg::MIX_W'(p_qq_ff);
   assign im_in = fqd_pkg::MIX_W'(p_qi_ff) - fqd_pkg::MIX_W'(p_iq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         last_i_ff <= '0;
         last_q_ff <= '0;
      end else begin
         if (load1) begin
            vld1_ff <= in_valid;
         end
         if (load2) begin
            vld2_ff <= vld1_ff;
         end
         if (accept) begin
            last_i_ff <= cur_i_in;
            last_q_ff <= cur_q_in;
         end
      end
   end

   // product with the conjugate of the previous sample
   always_ff @(posedge clock) begin
      if (load1) begin
         p_ii_ff <= cur_i_in * last_i_ff;
         p_qq_ff <= cur_q_in * last_q_ff;
         p_qi_ff <= cur_q_in * last_i_ff;
         p_iq_ff <= cur_i_in * last_q_ff;
      end
      if (load2) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;

endmodule

@@ hw/rtl/fqd_cordic.sv @@
`timescale 1ns / 1ps

module fqd_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [fqd_pkg::MIX_W-1:0]   in_re,
   input  logic signed [fqd_pkg::MIX_W-1:0]   in_im,
   output logic                               out_valid,
   input  logic                               out_ready,
   output fqd_pkg::cordic_vec_type            out_vec
);

   localparam int N = fqd_pkg::CORDIC_ITER;

   fqd_pkg::cordic_vec_type vec_ff [N+1];
   fqd_pkg::cordic_vec_type pre_in;
   logic                    vld_ff [N+1];
   logic [N:0]              load;
   logic signed [fqd_pkg::XY_W-1:0] re_ext, im_ext;

   assign load[N]  = !vld_ff[N] || out_ready;
   assign in_ready = load[0];

   // pre-rotation into the right half plane
   always_comb begin
      re_ext      = fqd_pkg::XY_W'(in_re);
      im_ext      = fqd_pkg::XY_W'(in_im);
      pre_in.zero = (in_re == '0) && (in_im == '0);
      if (in_re < 0) begin
         pre_in.x = -re_ext;
         pre_in.y = -im_ext;
         pre_in.z = (in_im < 0) ? -fqd_pkg::PI_Z : fqd_pkg::PI_Z;
      end else begin
         pre_in.x = re_ext;
         pre_in.y = im_ext;
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (load[0]) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         vec_ff[0] <= pre_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_iter
      fqd_pkg::cordic_vec_type         cur, vec_in;
      logic signed [fqd_pkg::XY_W-1:0] xs, ys;
      logic signed [fqd_pkg::Z_W-1:0]  ang;

      assign load[k] = !vld_ff[k] || load[k+1];

      always_comb begin
         cur         = vec_ff[k];
         xs          = cur.x >>> k;
         ys          = cur.y >>> k;
         ang         = $signed(fqd_pkg::ATAN_TABLE[k]);
         vec_in.zero = cur.zero;
         if (cur.y < 0) begin
            vec_in.x = cur.x - ys;
            vec_in.y = cur.y + xs;
            vec_in.z = cur.z - ang;
         end else begin
            vec_in.x = cur.x + ys;
            vec_in.y = cur.y - xs;
            vec_in.z = cur.z + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (load[k+1]) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (load[k+1]) begin
            vec_ff[k+1] <= vec_in;
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_vec   = vec_ff[N];

endmodule

@@ hw/rtl/fqd_scaler.sv @@
`timescale 1ns / 1ps

module fqd_scaler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  fqd_pkg::cordic_vec_type             in_vec,
   input  logic [fqd_pkg::GAIN_W-1:0]          gain,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [fqd_pkg::FREQ_W-1:0]   out_freq
);

   logic signed [fqd_pkg::Z_W-1:0]       z_rnd, z_shift;
   logic signed [fqd_pkg::ANGLE_W-1:0]   angle_ff, angle_in;
   logic signed [fqd_pkg::SCALED_W-1:0]  prod_ff, prod_in, prod_rnd;
   logic signed [fqd_pkg::ROUNDED_W-1:0] scaled;
   logic signed [fqd_pkg::FREQ_W-1:0]    freq_ff, freq_in;
   logic                                 vld1_ff, vld2_ff, vld3_ff;
   logic                                 load1, load2, load3;

   assign load3    = !vld3_ff || out_ready;
   assign load2    = !vld2_ff || load3;
   assign load1    = !vld1_ff || load2;
   assign in_ready = load1;

   // round half up to pi/32768, zero product gives zero angle
   assign z_rnd    = in_vec.z + $signed(fqd_pkg::Z_W'(32768));
   assign z_shift  = z_rnd >>> fqd_pkg::ANGLE_SHIFT;
   assign angle_in = in_vec.zero ? '0 : z_shift[fqd_pkg::ANGLE_W-1:0];

   assign prod_in = angle_ff * $signed({1'b0, gain});

   assign prod_rnd = prod_ff + $signed(fqd_pkg::SCALED_W'(1024));
   assign scaled   = prod_rnd[fqd_pkg::SCALED_W-1:fqd_pkg::ROUND_SHIFT];

   always_comb begin
      if (scaled > fqd_pkg::FREQ_MAX) begin
         freq_in = fqd_pkg::FREQ_MAX[fqd_pkg::FREQ_W-1:0];
      end else if (scaled < fqd_pkg::FREQ_MIN) begin
         freq_in = fqd_pkg::FREQ_MIN[fqd_pkg::FREQ_W-1:0];
      end else begin
         freq_in = scaled[fqd_pkg::FREQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (load1) begin
            vld1_ff <= in_valid;
         end
         if (load2) begin
            vld2_ff <= vld1_ff;
         end
         if (load3) begin
            vld3_ff <= vld2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         angle_ff <= angle_in;
      end
      if (load2) begin
         prod_ff <= prod_in;
      end
      if (load3) begin
         freq_ff <= freq_in;
      end
   end

   assign out_valid = vld3_ff;
   assign out_freq  = freq_ff;

endmodule

@@ hw/rtl/fm_quadrature_discriminator.sv @@
`timescale 1ns / 1ps
// throughput: one request per cycle unless a stalled response backs the pipeline up
// to the request side, every stage is a register with its own valid bit
// a stalled response only holds the stages that are full, bubbles behind it still fill
// reset (synchronous, active high) empties the pipeline, zeroes the previous sample
// and loads the gain register with 8250

module fm_quadrature_discriminator (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fqd_pkg::SAMPLE_W-1:0] req_sample_i,
   input  logic signed [fqd_pkg::SAMPLE_W-1:0] req_sample_q,
   input  logic                                req_squelch_open,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fqd_pkg::FREQ_W-1:0]   rsp_freq_value,
   // gain register
   input  logic                                csr_write_en,
   input  logic [fqd_pkg::GAIN_W-1:0]          csr_write_data
);

   logic [fqd_pkg::GAIN_W-1:0]        gain_ff;

   logic                              mix_valid, mix_ready;
   logic signed [fqd_pkg::MIX_W-1:0]  mix_re, mix_im;

   logic                              cor_valid, cor_ready;
   fqd_pkg::cordic_vec_type           cor_vec;

   // gain times pi, unsigned Q8.8; user writes only while pipeline is empty, unchecked
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= fqd_pkg::GAIN_RESET;
      end else if (csr_write_en) begin
         gain_ff <= csr_write_data;
      end
   end

   // two stages: squelch gating and the four products, then re/im sums.
   // the previous sample is updated on every accepted request
   fqd_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_i      (req_sample_i),
      .in_q      (req_sample_q),
      .in_open   (req_squelch_open),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_re    (mix_re),
      .out_im    (mix_im)
   );

   // one pre-rotation stage, then one register stage per cordic iteration
   fqd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_re     (mix_re),
      .in_im     (mix_im),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .out_vec   (cor_vec)
   );

   // angle rounding, gain multiply, round and saturate into the response register
   fqd_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .in_ready  (cor_ready),
      .in_vec    (cor_vec),
      .gain      (gain_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_freq  (rsp_freq_value)
   );

endmodule

@@ dv/fm_quadrature_discriminator_tb.sv @@
`timescale 1ns / 1ps

module fm_quadrature_discriminator_tb;

   // run limit in clock cycles, far above the slowest correct run
   localparam int CYCLE_LIMIT = 400000;
   localparam int ARCTAN_LEN  = 24;
   localparam int PEND_DEPTH  = 256;
   localparam longint PI_ACC  = 64'sd2147483648;
   localparam longint FREQ_HI = 1048575;
   localparam longint FREQ_LO = -1048576;

   // atan(2^-k) in units of pi/2^31
   localparam longint ARCTAN [ARCTAN_LEN] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   // tracks gain and previous sample, predicts freq_value per request
   class freq_predictor;
      logic [fqd_pkg::GAIN_W-1:0]          gain;
      logic signed [fqd_pkg::SAMPLE_W-1:0] prev_i;
      logic signed [fqd_pkg::SAMPLE_W-1:0] prev_q;
      logic signed [fqd_pkg::FREQ_W-1:0]   pending_freq [PEND_DEPTH];
      int                                  pend_head;
      int                                  pend_count;
      int                                  mismatches;

      function new();
         gain       = fqd_pkg::GAIN_RESET;
         prev_i     = '0;
         prev_q     = '0;
         pend_head  = 0;
         pend_count = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return pend_count;
      endfunction

      // append one expected response in request order
      function void queue_result(logic signed [fqd_pkg::FREQ_W-1:0] v);
         if (pend_count == PEND_DEPTH) begin
            $display("%0t: too many requests without a response", $time);
            mismatches++;
            return;
         end
         pending_freq[(pend_head + pend_count) % PEND_DEPTH] = v;
         pend_count++;
      endfunction

      // phase of (re, im) in units of pi/32768
      function longint phase_of(longint re, longint im);
         longint x, y, z, xs, ys;
         int     iters;
         if (re == 0 && im == 0)
            return 0;
         x = re;
         y = im;
         z = 0;
         iters = (fqd_pkg::CORDIC_STAGES < ARCTAN_LEN) ? fqd_pkg::CORDIC_STAGES : ARCTAN_LEN;
         // left half plane: flip the vector and start from +/- pi
         if (x < 0) begin
            z = (im < 0) ? -PI_ACC : PI_ACC;
            x = -x;
            y = -y;
         end
         for (int k = 0; k < iters; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y < 0) begin
               x = x - ys;
               y = y + xs;
               z = z - ARCTAN[k];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + ARCTAN[k];
            end
         end
         return (z + 32768) >>> 16;
      endfunction

      function void note_sample(logic signed [fqd_pkg::SAMPLE_W-1:0] si,
                                logic signed [fqd_pkg::SAMPLE_W-1:0] sq,
                                logic squelch_open);
         logic signed [fqd_pkg::SAMPLE_W-1:0] cur_i, cur_q;
         longint re, im, freq;
         cur_i = squelch_open ? si : '0;
         cur_q = squelch_open ? sq : '0;
         re = longint'(cur_i) * longint'(prev_i) + longint'(cur_q) * longint'(prev_q);
         im = longint'(cur_q) * longint'(prev_i) - longint'(cur_i) * longint'(prev_q);
         freq = (phase_of(re, im) * longint'(gain) + 1024) >>> 11;
         if (freq > FREQ_HI)
            freq = FREQ_HI;
         if (freq < FREQ_LO)
            freq = FREQ_LO;
         queue_result(freq[fqd_pkg::FREQ_W-1:0]);
         prev_i = cur_i;
         prev_q = cur_q;
      endfunction

      function void check_freq(logic signed [fqd_pkg::FREQ_W-1:0] got);
         logic signed [fqd_pkg::FREQ_W-1:0] want;
         if (pend_count == 0) begin
            $display("%0t: freq_value %0d with none expected", $time, got);
            mismatches++;
            return;
         end
         want       = pending_freq[pend_head];
         pend_head  = (pend_head + 1) % PEND_DEPTH;
         pend_count--;
         if (got !== want) begin
            $display("%0t: freq_value mismatch, expected %0d, got %0d", $time, want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [fqd_pkg::SAMPLE_W-1:0] req_sample_i;
   logic signed [fqd_pkg::SAMPLE_W-1:0] req_sample_q;
   logic                                req_squelch_open;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [fqd_pkg::FREQ_W-1:0]   rsp_freq_value;
   logic                                csr_write_en;
   logic [fqd_pkg::GAIN_W-1:0]          csr_write_data;

   freq_predictor tracker;

   // idling switches and the long receiver hold-off request
   bit  tx_idle_en;
   bit  rx_idle_en;
   int  hold_ask;
   int  cycle_count;

   // history for the shaped random requests
   int  last_sent_i;
   int  last_sent_q;
   real carrier_phase;
   real carrier_step;
   real carrier_amp;

   fm_quadrature_discriminator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_i     (req_sample_i),
      .req_sample_q     (req_sample_q),
      .req_squelch_open (req_squelch_open),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_freq_value   (rsp_freq_value),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // monitor: gain writes, accepted requests and responses, all sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en)
            tracker.gain = csr_write_data;
         if (req_valid && req_ready)
            tracker.note_sample(req_sample_i, req_sample_q, req_squelch_open);
         if (rsp_valid && rsp_ready)
            tracker.check_freq(rsp_freq_value);
      end
   end

   // response side: random stall bursts plus the long hold-off, counted here
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one request, with an occasional idle burst first; valid stays up between
   // back-to-back requests
   task automatic send_sample(input int si, input int sq, input bit squelch_open);
      int gap;
      gap = 0;
      if (tx_idle_en && $urandom_range(0, 6) == 0)
         gap = $urandom_range(1, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_sample_i     <= fqd_pkg::SAMPLE_W'(si);
      req_sample_q     <= fqd_pkg::SAMPLE_W'(sq);
      req_squelch_open <= squelch_open;
      do
         @(posedge clock);
      while (!req_ready);
      last_sent_i = int'(req_sample_i);
      last_sent_q = int'(req_sample_q);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // gain writes only while the pipeline is empty
   task automatic write_gain(input logic [fqd_pkg::GAIN_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // a clean fm carrier in 45 of 100 cases, mixed with noise, squelch gaps and corner vectors
   task automatic send_random_sample();
      int si, sq;
      bit squelch_open;
      int kind;
      kind = $urandom_range(0, 99);
      squelch_open = ($urandom_range(0, 19) != 0);
      if (kind < 45) begin
         if ($urandom_range(0, 15) == 0) begin
            carrier_step = (real'($urandom_range(0, 6282)) - 3141.0) / 1000.0;
            carrier_amp  = real'($urandom_range(1, 32767));
         end
         carrier_phase = carrier_phase + carrier_step;
         si = $rtoi(carrier_amp * $cos(carrier_phase));
         sq = $rtoi(carrier_amp * $sin(carrier_phase));
      end else if (kind < 60) begin
         si = $urandom;
         sq = $urandom;
      end else if (kind < 70) begin
         si = $urandom;
         sq = $urandom;
         squelch_open = 1'b0;
      end else if (kind < 80) begin
         si = int'($urandom_range(0, 6)) - 3;
         sq = int'($urandom_range(0, 6)) - 3;
      end else if (kind < 88) begin
         // same vector again: zero imaginary part
         si = last_sent_i;
         sq = last_sent_q;
      end else if (kind < 95) begin
         // near-opposite vector: around +/- pi
         si = ~last_sent_i;
         sq = last_sent_q ^ int'($urandom_range(0, 1));
         sq = ~sq;
      end else begin
         case ($urandom_range(0, 3))
            0: si = -32768;
            1: si = 32767;
            2: si = 0;
            default: si = -1;
         endcase
         case ($urandom_range(0, 3))
            0: sq = -32768;
            1: sq = 32767;
            2: sq = 0;
            default: sq = -1;
         endcase
      end
      send_sample(si, sq, squelch_open);
   endtask

   initial begin
      tracker          = new();
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_i     = '0;
      req_sample_q     = '0;
      req_squelch_open = 1'b0;
      rsp_ready        = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      tx_idle_en       = 1'b1;
      rx_idle_en       = 1'b1;
      hold_ask         = 0;
      cycle_count      = 0;
      last_sent_i      = 0;
      last_sent_q      = 0;
      carrier_phase    = 0.0;
      carrier_step     = 0.3;
      carrier_amp      = 20000.0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at the reset gain
      send_sample(0, 0, 1'b1);              // zero product, previous is zero after reset
      send_sample(32767, 0, 1'b1);          // still zero product
      send_sample(32767, 0, 1'b1);          // same vector, imaginary part exactly zero
      send_sample(0, 32767, 1'b1);          // quarter turn
      send_sample(-32768, 0, 1'b1);
      send_sample(32767, 0, 1'b1);          // negative real, zero imaginary: start at +pi
      send_sample(-32768, -1, 1'b1);        // negative real, negative imaginary: start at -pi
      send_sample(-32768, -32768, 1'b1);
      send_sample(-32768, -32768, 1'b1);    // largest real product
      send_sample(32767, 32767, 1'b1);
      send_sample(-32768, 32767, 1'b1);
      send_sample(32767, -32768, 1'b1);
      send_sample(-32768, -32768, 1'b0);    // squelch closed forces zero
      send_sample(12345, -32768, 1'b1);     // zero product after a squelched request
      send_sample(-1, -1, 1'b1);
      send_sample(1, 1, 1'b1);
      send_sample(1, -1, 1'b1);
      send_sample(0, -32768, 1'b1);
      send_sample(-1, 0, 1'b1);
      send_sample(32767, 32767, 1'b0);
      send_sample(-21846, 21845, 1'b1);
      send_sample(21845, -21846, 1'b1);
      stop_sending();

      // gain extremes and in-between settings
      write_gain(16'd0);
      repeat (100) send_random_sample();
      stop_sending();

      write_gain(16'hFFFF);
      repeat (100) send_random_sample();
      stop_sending();

      write_gain(16'd1);
      repeat (60) send_random_sample();
      stop_sending();

      write_gain(fqd_pkg::GAIN_W'($urandom));
      repeat (120) send_random_sample();
      stop_sending();

      // long response hold-off with back-to-back requests to back up the pipeline
      write_gain(fqd_pkg::GAIN_W'($urandom));
      tx_idle_en = 1'b0;
      hold_ask   = 150;
      repeat (80) send_random_sample();
      stop_sending();
      tx_idle_en = 1'b1;

      // last stretch with no idling on either side
      write_gain(fqd_pkg::GAIN_W'($urandom));
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      repeat (140) send_random_sample();
      stop_sending();

      wait_drained();
      repeat (40) @(posedge clock);
      if (tracker.outstanding() != 0)
         $display("%0t: %0d responses never arrived", $time, tracker.outstanding());
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
